// File: hdl/yrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_pkg
// Shared types and constants for the YUYV to RGB565 centred blit.
// ----------------------------------------------------------------------------
package yrb_pkg;

  localparam int SIDE_W = 13;
  localparam int CNT_W  = 12;
  localparam int POS_W  = 14;
  localparam int ADDR_W = 24;
  localparam int SUM_W  = 19;

  localparam logic [SIDE_W-1:0] MAX_SIDE = 13'd4096;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd3;

  localparam logic [SIDE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic signed [SUM_W-1:0] COEF_Y  = 19'sd298;
  localparam logic signed [SUM_W-1:0] COEF_RV = 19'sd409;
  localparam logic signed [SUM_W-1:0] COEF_GU = 19'sd100;
  localparam logic signed [SUM_W-1:0] COEF_GV = 19'sd208;
  localparam logic signed [SUM_W-1:0] COEF_BU = 19'sd516;
  localparam logic signed [SUM_W-1:0] ROUND   = 19'sd128;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 19'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 19'sd128;

  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] first_address;
    logic [15:0]       first_pixel;
    logic              first_enable;
    logic [ADDR_W-1:0] second_address;
    logic [15:0]       second_pixel;
    logic              second_enable;
    logic              frame_done;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [15:0]       pixel;
    logic              enable;
  } lane_res_t;

endpackage

// File: hdl/yuyv_to_rgb565_centered_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_centered_blit
// YUYV macropixel stream to two RGB565 pixels with centred screen addresses.
//
// The input channel (in_valid / in_ready / in_data) takes one macropixel
// Y0 U Y1 V per transfer. The output channel (out_valid / out_ready /
// out_data) gives one result per macropixel: screen address, colour and
// write enable for each of the two pixels, plus frame_done on the last
// macropixel of the source frame. Source column and row counters advance
// two columns per transfer and wrap at the end of the frame.
// A result passes through the stage-1 register and then the output register;
// throughput is one macropixel per cycle while the receiver takes results,
// set by the two-stage pipeline with a lane per pixel and one
// address multiplier in each lane.
// A stalled receiver holds the output register and the stage behind it;
// in_ready drops only when both are full.
// Reset empties the pipeline, zeroes the counters and loads the default
// 640 x 480 sizes. The cfg port writes a size register; the user must
// use it only while no transfer is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_centered_blit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  yrb_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output yrb_pkg::out_t               out_data,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [yrb_pkg::SIDE_W-1:0]  cfg_data
);

  localparam int SDW = yrb_pkg::SIDE_W;
  localparam int PW  = yrb_pkg::POS_W;
  localparam int CW  = yrb_pkg::CNT_W;

  function automatic logic [SDW-1:0] clamp_side(input logic [SDW-1:0] v);
    clamp_side = (v > yrb_pkg::MAX_SIDE) ? yrb_pkg::MAX_SIDE : v;
  endfunction

  logic [SDW-1:0] screen_width, screen_height, source_width, source_height;
  logic [SDW-1:0] sw, sh, w, h;
  logic signed [PW-1:0] xdiff, ydiff, xhalf, yhalf, xoff, yoff;
  logic signed [PW-1:0] fx, fy;
  logic row_end, frame_end;

  logic [CW-1:0] source_column, source_row;
  logic [CW-1:0] source_column_next, source_row_next;

  logic            s1_valid;
  logic [7:0]      s1_luma_first, s1_luma_second, s1_chroma_blue, s1_chroma_red;
  logic signed [PW-1:0] s1_x, s1_y, s1_x_second;
  logic            s1_frame_end;

  logic out_en, s1_en, in_xfer;
  yrb_pkg::lane_res_t res_first, res_second;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= yrb_pkg::RESET_WIDTH;
      screen_height <= yrb_pkg::RESET_HEIGHT;
      source_width  <= yrb_pkg::RESET_WIDTH;
      source_height <= yrb_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        yrb_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        yrb_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        yrb_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        yrb_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sw = clamp_side(screen_width);
  assign sh = clamp_side(screen_height);
  assign w  = clamp_side(source_width) & {{(SDW-1){1'b1}}, 1'b0};
  assign h  = clamp_side(source_height);

  // centring offset, halved with truncation toward zero
  assign xdiff = $signed({1'b0, sw}) - $signed({1'b0, w});
  assign ydiff = $signed({1'b0, sh}) - $signed({1'b0, h});
  assign xhalf = xdiff + $signed({{(PW-1){1'b0}}, xdiff[PW-1]});
  assign yhalf = ydiff + $signed({{(PW-1){1'b0}}, ydiff[PW-1]});
  assign xoff  = xhalf >>> 1;
  assign yoff  = yhalf >>> 1;

  assign fx = $signed({{(PW-CW){1'b0}}, source_column}) + xoff;
  assign fy = $signed({{(PW-CW){1'b0}}, source_row}) + yoff;

  assign row_end   = ({1'b0, source_column} + SDW'(2)) >= w;
  assign frame_end = row_end && (({1'b0, source_row} + SDW'(1)) >= h);

  always_comb begin
    source_column_next = source_column + CW'(2);
    source_row_next    = source_row;
    if (row_end) begin
      source_column_next = '0;
      source_row_next    = frame_end ? '0 : source_row + CW'(1);
    end
  end

  // pipeline control
  assign out_en   = !out_valid || out_ready;
  assign s1_en    = !s1_valid || out_en;
  assign in_ready = s1_en;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_xfer) begin
        source_column <= source_column_next;
        source_row    <= source_row_next;
      end
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (out_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_luma_first  <= in_data.luma_first;
      s1_luma_second <= in_data.luma_second;
      s1_chroma_blue <= in_data.chroma_blue;
      s1_chroma_red  <= in_data.chroma_red;
      s1_x           <= fx;
      s1_y           <= fy;
      s1_frame_end   <= frame_end;
    end
  end

  assign s1_x_second = s1_x + PW'(1);

  yrb_lane u_lane_first (
    .luma          (s1_luma_first),
    .chroma_blue   (s1_chroma_blue),
    .chroma_red    (s1_chroma_red),
    .column        (s1_x),
    .row           (s1_y),
    .screen_width  (sw),
    .screen_height (sh),
    .result        (res_first)
  );

  yrb_lane u_lane_second (
    .luma          (s1_luma_second),
    .chroma_blue   (s1_chroma_blue),
    .chroma_red    (s1_chroma_red),
    .column        (s1_x_second),
    .row           (s1_y),
    .screen_width  (sw),
    .screen_height (sh),
    .result        (res_second)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      out_data.first_address  <= res_first.address;
      out_data.first_pixel    <= res_first.pixel;
      out_data.first_enable   <= res_first.enable;
      out_data.second_address <= res_second.address;
      out_data.second_pixel   <= res_second.pixel;
      out_data.second_enable  <= res_second.enable;
      out_data.frame_done     <= s1_frame_end;
    end
  end

endmodule

// File: hdl/yrb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_lane
// One pixel lane: BT.601 colour conversion to RGB565 and screen placement.
// ----------------------------------------------------------------------------
module yrb_lane (
  input  logic [7:0]                        luma,
  input  logic [7:0]                        chroma_blue,
  input  logic [7:0]                        chroma_red,
  input  logic signed [yrb_pkg::POS_W-1:0]  column,
  input  logic signed [yrb_pkg::POS_W-1:0]  row,
  input  logic [yrb_pkg::SIDE_W-1:0]        screen_width,
  input  logic [yrb_pkg::SIDE_W-1:0]        screen_height,
  output yrb_pkg::lane_res_t                result
);

  localparam int SW = yrb_pkg::SUM_W;

  function automatic logic [7:0] clamp_channel(input logic signed [SW-1:0] sum);
    logic [SW-9:0] hi;
    hi = sum[SW-1:8];
    if (sum[SW-1]) begin
      clamp_channel = 8'd0;
    end else if (hi > (SW-8)'(255)) begin
      clamp_channel = 8'hFF;
    end else begin
      clamp_channel = hi[7:0];
    end
  endfunction

  logic signed [SW-1:0] c, d, e;
  logic signed [SW-1:0] r_sum, g_sum, b_sum;
  logic [7:0] r, g, b;
  logic on_screen;
  logic [yrb_pkg::ADDR_W-1:0] product;
  logic [yrb_pkg::ADDR_W-1:0] address;

  assign c = $signed({{(SW-8){1'b0}}, luma}) - yrb_pkg::LUMA_OFFSET;
  assign d = $signed({{(SW-8){1'b0}}, chroma_blue}) - yrb_pkg::CHROMA_OFFSET;
  assign e = $signed({{(SW-8){1'b0}}, chroma_red}) - yrb_pkg::CHROMA_OFFSET;

  assign r_sum = yrb_pkg::COEF_Y * c + yrb_pkg::COEF_RV * e + yrb_pkg::ROUND;
  assign g_sum = yrb_pkg::COEF_Y * c - yrb_pkg::COEF_GU * d - yrb_pkg::COEF_GV * e
                 + yrb_pkg::ROUND;
  assign b_sum = yrb_pkg::COEF_Y * c + yrb_pkg::COEF_BU * d + yrb_pkg::ROUND;

  assign r = clamp_channel(r_sum);
  assign g = clamp_channel(g_sum);
  assign b = clamp_channel(b_sum);

  // clipping against the visible screen
  assign on_screen = !column[yrb_pkg::POS_W-1] && !row[yrb_pkg::POS_W-1]
                     && (column[yrb_pkg::SIDE_W-1:0] < screen_width)
                     && (row[yrb_pkg::SIDE_W-1:0] < screen_height);

  assign product = yrb_pkg::ADDR_W'(row[yrb_pkg::CNT_W-1:0])
                   * yrb_pkg::ADDR_W'(screen_width);
  assign address = product
                   + yrb_pkg::ADDR_W'(column[yrb_pkg::SIDE_W-1:0]);

  assign result.address = on_screen ? address : '0;
  assign result.enable  = on_screen;
  assign result.pixel   = {r & yrb_pkg::RED_MASK, 8'h00}
                          | {5'b0, g & yrb_pkg::GREEN_MASK, 3'b0}
                          | {11'b0, b[7:3]};

endmodule

// File: hdl/yrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_checker
// Port-level assertions for the YUYV to RGB565 centred blit.
// ----------------------------------------------------------------------------
module yrb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input yrb_pkg::out_t               out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with output register empty");

  // clipped pixels carry a zero address
  a_clip_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!out_data.first_enable || !out_data.second_enable) |->
      (out_data.first_enable || out_data.first_address == '0) &&
      (out_data.second_enable || out_data.second_address == '0))
    else $error("clipped pixel with non-zero address");

  // both pixels of a pair sit side by side on the same row
  a_pair_adjacent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.first_enable && out_data.second_enable |->
      out_data.second_address == out_data.first_address + 24'd1)
    else $error("pixel pair not adjacent");

  // the output is not valid straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind yuyv_to_rgb565_centered_blit yrb_checker u_yrb_checker (.*);

// File: dv/tb_yuyv_to_rgb565_centered_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb565_centered_blit
// Self-checking bench for the YUYV to RGB565 centred blit.
//
// A queue of macropixels feeds a valid/ready driver. The monitor predicts
// the colour, screen address, enable and end-of-frame flag of each pair as
// its input transfer is taken, and checks every output transfer field by
// field against the oldest prediction. The sizes are rewritten between
// phases while the pipeline is empty: reset defaults, oversized, zero,
// odd and minimum sizes, then random settings. The counters are not
// cleared between phases, so sizes also change in mid-frame.
// Both sides idle at random, with one calm phase and one long output stall.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb565_centered_blit;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1350;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  yrb_pkg::in_t               in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  yrb_pkg::out_t              out_data;
  logic                       cfg_write = 1'b0;
  logic [1:0]                 cfg_index = yrb_pkg::REG_SCREEN_WIDTH;
  logic [yrb_pkg::SIDE_W-1:0] cfg_data = '0;

  // predictor copy of the size registers and the source counters
  logic [yrb_pkg::SIDE_W-1:0] scr_w = yrb_pkg::RESET_WIDTH;
  logic [yrb_pkg::SIDE_W-1:0] scr_h = yrb_pkg::RESET_HEIGHT;
  logic [yrb_pkg::SIDE_W-1:0] src_w = yrb_pkg::RESET_WIDTH;
  logic [yrb_pkg::SIDE_W-1:0] src_h = yrb_pkg::RESET_HEIGHT;
  int                         col_count = 0;
  int                         row_count = 0;

  yrb_pkg::in_t  macropixels_to_send[$];
  yrb_pkg::out_t due_pairs[$];

  logic in_taken = 1'b0;
  logic calm = 1'b0;
  logic held_once = 1'b0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   pairs_checked = 0;
  int   frames_completed = 0;
  int   pixels_clipped = 0;
  int   settings_used = 0;
  int   items_queued = 0;
  int   cycle_count = 0;

  yuyv_to_rgb565_centered_blit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int side(logic [yrb_pkg::SIDE_W-1:0] v);
    return (v > yrb_pkg::MAX_SIDE) ? int'(yrb_pkg::MAX_SIDE) : int'(v);
  endfunction

  function automatic logic [7:0] channel(int sum);
    if (sum < 0) begin
      return 8'd0;
    end
    return ((sum >>> 8) > 255) ? 8'd255 : 8'(sum >>> 8);
  endfunction

  function automatic logic [15:0] rgb565(logic [7:0] luma, int d, int e);
    int c;
    logic [7:0] r, g, b;
    c = int'(luma) - 16;
    r = channel(298 * c + 409 * e + 128);
    g = channel(298 * c - 100 * d - 208 * e + 128);
    b = channel(298 * c + 516 * d + 128);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // {address, enable} of a screen position, zero when off screen
  function automatic logic [yrb_pkg::ADDR_W:0] place(int x, int y, int sw, int sh);
    longint lin;
    if (x >= 0 && y >= 0 && x < sw && y < sh) begin
      lin = longint'(y) * sw + x;
      return {lin[yrb_pkg::ADDR_W-1:0], 1'b1};
    end
    return '0;
  endfunction

  function automatic yrb_pkg::out_t blit_macropixel(yrb_pkg::in_t mp);
    yrb_pkg::out_t res;
    int   sw, sh, w, h, d, e, fx, fy;
    logic row_end, frame_end;
    sw = side(scr_w);
    sh = side(scr_h);
    w  = side(src_w) & ~1;
    h  = side(src_h);
    d  = int'(mp.chroma_blue) - 128;
    e  = int'(mp.chroma_red) - 128;
    fx = col_count + (sw - w) / 2;
    fy = row_count + (sh - h) / 2;
    row_end   = (col_count + 2 >= w);
    frame_end = row_end && (row_count + 1 >= h);
    {res.first_address, res.first_enable}   = place(fx, fy, sw, sh);
    {res.second_address, res.second_enable} = place(fx + 1, fy, sw, sh);
    res.first_pixel  = rgb565(mp.luma_first, d, e);
    res.second_pixel = rgb565(mp.luma_second, d, e);
    res.frame_done   = frame_end;
    if (row_end) begin
      col_count = 0;
      row_count = frame_end ? 0 : row_count + 1;
    end else begin
      col_count = col_count + 2;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at pair %0d: expected %0h, got %0h",
               field, pairs_checked, want, got);
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (macropixels_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_data  <= macropixels_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // output ready, with one long hold-off while the queue is well stocked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rst && !held_once && macropixels_to_send.size() > 60) begin
      held_once = 1'b1;
      hold_left = 50;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // monitor: check results first, then predict for the input transfer
  always @(posedge clk) begin
    yrb_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_pairs.size() == 0) begin
          report_mismatch("unexpected result", 0, longint'(out_data.first_address));
        end else begin
          want = due_pairs.pop_front();
          if (out_data.first_address !== want.first_address)
            report_mismatch("first_address", longint'(want.first_address),
                            longint'(out_data.first_address));
          if (out_data.first_pixel !== want.first_pixel)
            report_mismatch("first_pixel", longint'(want.first_pixel),
                            longint'(out_data.first_pixel));
          if (out_data.first_enable !== want.first_enable)
            report_mismatch("first_enable", longint'(want.first_enable),
                            longint'(out_data.first_enable));
          if (out_data.second_address !== want.second_address)
            report_mismatch("second_address", longint'(want.second_address),
                            longint'(out_data.second_address));
          if (out_data.second_pixel !== want.second_pixel)
            report_mismatch("second_pixel", longint'(want.second_pixel),
                            longint'(out_data.second_pixel));
          if (out_data.second_enable !== want.second_enable)
            report_mismatch("second_enable", longint'(want.second_enable),
                            longint'(out_data.second_enable));
          if (out_data.frame_done !== want.frame_done)
            report_mismatch("frame_done", longint'(want.frame_done),
                            longint'(out_data.frame_done));
          pairs_checked++;
          frames_completed += int'(want.frame_done);
          pixels_clipped += int'(!want.first_enable) + int'(!want.second_enable);
        end
      end
      if (in_valid && in_ready) begin
        due_pairs.push_back(blit_macropixel(in_data));
        in_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [yrb_pkg::SIDE_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      yrb_pkg::REG_SCREEN_WIDTH:  scr_w = val;
      yrb_pkg::REG_SCREEN_HEIGHT: scr_h = val;
      yrb_pkg::REG_SOURCE_WIDTH:  src_w = val;
      default:                    src_h = val;
    endcase
  endtask

  task automatic set_sizes(logic [yrb_pkg::SIDE_W-1:0] sw, logic [yrb_pkg::SIDE_W-1:0] sh,
                           logic [yrb_pkg::SIDE_W-1:0] w, logic [yrb_pkg::SIDE_W-1:0] h);
    write_reg(yrb_pkg::REG_SCREEN_WIDTH, sw);
    write_reg(yrb_pkg::REG_SCREEN_HEIGHT, sh);
    write_reg(yrb_pkg::REG_SOURCE_WIDTH, w);
    write_reg(yrb_pkg::REG_SOURCE_HEIGHT, h);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd128;
      4:       return 8'd235;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [yrb_pkg::SIDE_W-1:0] pick_side();
    case ($urandom_range(0, 23))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4095;
      3:       return 13'd4096;
      4:       return 13'd4097;
      5:       return 13'd8191;
      default: return 13'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic queue_random(int n);
    yrb_pkg::in_t mp;
    repeat (n) begin
      mp.luma_first  = pick_byte();
      mp.chroma_blue = pick_byte();
      mp.luma_second = pick_byte();
      mp.chroma_red  = pick_byte();
      macropixels_to_send.push_back(mp);
      items_queued++;
    end
  endtask

  task automatic queue_mp(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
    macropixels_to_send.push_back('{y0, u, y1, v});
    items_queued++;
  endtask

  task automatic drain();
    while (macropixels_to_send.size() > 0 || in_valid || due_pairs.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    int phase;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // colour extremes at the reset sizes
    queue_mp(8'd0, 8'd0, 8'd0, 8'd0);
    queue_mp(8'd255, 8'd255, 8'd255, 8'd255);
    queue_mp(8'd16, 8'd128, 8'd235, 8'd128);
    queue_mp(8'd235, 8'd128, 8'd16, 8'd128);
    queue_mp(8'd255, 8'd0, 8'd255, 8'd0);
    queue_mp(8'd0, 8'd255, 8'd0, 8'd255);
    queue_mp(8'd128, 8'd0, 8'd128, 8'd255);
    queue_mp(8'd128, 8'd255, 8'd128, 8'd0);
    queue_mp(8'd81, 8'd90, 8'd81, 8'd240);
    queue_mp(8'd145, 8'd54, 8'd145, 8'd34);
    queue_mp(8'd41, 8'd240, 8'd41, 8'd110);
    queue_mp(8'd255, 8'd128, 8'd0, 8'd128);
    queue_mp(8'd128, 8'd128, 8'd128, 8'd128);
    queue_mp(8'd170, 8'd85, 8'd85, 8'd170);
    drain();

    // oversized registers
    set_sizes(13'd8191, 13'd8191, 13'd8191, 13'd8191);
    queue_random(30);
    drain();
    // odd source width, zero source height
    set_sizes(13'd12, 13'd7, 13'd5, 13'd0);
    queue_random(20);
    drain();
    // width of one: every transfer ends its row
    set_sizes(13'd9, 13'd5, 13'd1, 13'd3);
    queue_random(15);
    drain();
    // zero screen
    set_sizes(13'd0, 13'd0, 13'd6, 13'd3);
    queue_random(20);
    drain();
    // source larger than screen, negative offsets from odd differences
    set_sizes(13'd3, 13'd2, 13'd8, 13'd5);
    queue_random(50);
    drain();
    // largest screen, then shrink with counters far past the new sizes
    set_sizes(13'd4096, 13'd4096, 13'd4096, 13'd2);
    queue_random(40);
    drain();
    set_sizes(13'd1, 13'd1, 13'd2, 13'd1);
    queue_random(20);
    drain();

    phase = 0;
    while (items_queued < RANDOM_ITEMS) begin
      set_sizes(pick_side(), pick_side(), pick_side(), pick_side());
      calm = (phase == 1);
      queue_random(phase < 2 ? 120 : $urandom_range(40, 120));
      drain();
      calm = 1'b0;
      phase++;
    end

    repeat (10) @(negedge clk);
    mismatches += due_pairs.size();
    $display("%0d macropixels checked under %0d size settings", pairs_checked, settings_used);
    $display("%0d frames completed, %0d pixels clipped", frames_completed, pixels_clipped);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
